FILE: rtl/wmf_pkg.sv
// Shared constants and types of the windowed median image filter.
package wmf_pkg;

    localparam int WindowDef   = 3;
    localparam int MaxWidthDef = 2048;
    localparam int ChannelsDef = 3;

    localparam int MaxHeight   = 4096;
    localparam int FwW         = 12;
    localparam int FhW         = 13;
    localparam int ResetWidth  = 640;
    localparam int ResetHeight = 480;
    localparam int SampleW     = 8;
    localparam int OutChannels = 3;
    localparam int QueueDepth  = 4;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // control word that travels with each column fetch
    typedef struct packed {
        logic emit;       // column completes an output window
        logic frame_end;  // output pixel is the last of the frame
    } t_op_ctl;

endpackage

FILE: rtl/wmf_ram.sv
// Generic simple dual-port RAM, read-first, registered read.
module wmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/wmf_fifo.sv
// Short register queue between the fetch front end and the sorting back end.
module wmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_nempty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wptr, n_wptr;
    logic [PTRW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTRW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTRW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data   = r_mem[r_rptr];
    assign o_nempty = (r_cnt != '0);
    assign o_count  = r_cnt;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == CW'(DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("queue underflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

FILE: rtl/wmf_front.sv
// Front end: config registers, raster counters, line store banks, column fetch.
module wmf_front import wmf_pkg::*; #(
    parameter int WINDOW    = WindowDef,
    parameter int MAX_WIDTH = MaxWidthDef,
    parameter int CHANNELS  = ChannelsDef
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [OutChannels*SampleW-1:0]           i_pix,
    input  logic                                     i_drain,
    input  logic                                     i_cfg_we,
    input  t_cfg_idx                                 i_cfg_idx,
    input  logic [FhW-1:0]                           i_cfg_data,
    input  logic [$clog2(QueueDepth+1)-1:0]          i_qcount,
    output logic                                     o_push,
    output t_op_ctl                                  o_ctl,
    output logic [WINDOW*((CHANNELS < OutChannels) ? CHANNELS : OutChannels)*SampleW-1:0] o_col
);

    localparam int CH    = (CHANNELS < OutChannels) ? CHANNELS : OutChannels;
    localparam int PIXW  = CH * SampleW;
    localparam int HALF  = WINDOW / 2;
    // columns pushed before the first window of a row is complete
    localparam int PRIME = WINDOW - 1;
    // offset of the column that completes a window
    localparam int LEAD  = WINDOW - 1 - HALF;
    localparam int REACH = (WINDOW - 1) / 2;
    localparam int RING  = 2 * WINDOW;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int ROWW  = FhW;
    localparam int CNTW  = $clog2(MAX_WIDTH * MaxHeight + 1);
    localparam int BW    = $clog2(RING);
    localparam int PW    = (PRIME > 0) ? $clog2(PRIME + 1) : 1;

    // configuration
    logic [FwW-1:0] r_fw;
    logic [FhW-1:0] r_fh;
    logic [WW-1:0]  w_use;
    logic [FhW-1:0] h_use;
    logic [CNTW-1:0] total, lag;

    // raster positions
    logic [AW-1:0]   r_in_col,  n_in_col;
    logic [BW-1:0]   r_in_bank, n_in_bank;
    logic [CNTW-1:0] r_in_cnt,  n_in_cnt;
    logic [AW-1:0]   r_out_col, n_out_col;
    logic [ROWW-1:0] r_out_row, n_out_row;
    logic [BW-1:0]   r_out_bank, n_out_bank;
    logic [CNTW-1:0] r_out_cnt, n_out_cnt;

    // pending output pixel waiting for its fetches
    logic            r_pend, n_pend;
    logic [PW-1:0]   r_pidx, n_pidx;
    logic [AW-1:0]   r_p_col, n_p_col;
    logic [ROWW-1:0] r_p_row, n_p_row;
    logic [BW-1:0]   r_p_bank, n_p_bank;
    logic            r_p_fe, n_p_fe;

    // fetch stage
    logic            r_s1_vld;
    t_op_ctl         r_s1_ctl;
    logic [BW-1:0]   r_s1_sel [WINDOW];
    logic [BW-1:0]   sel [WINDOW];

    logic            room, issue, last_issue, priming, acc, emit, we;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   t_icol, t_ocol;
    logic [BW-1:0]   t_ibank, t_obank;
    logic [CNTW-1:0] t_icnt, t_ocnt;
    logic [ROWW-1:0] t_orow;
    logic [PIXW-1:0] rdata [RING];

    // saturated frame geometry
    always_comb begin
        if (r_fw == '0) begin
            w_use = WW'(1);
        end else if (int'(r_fw) > MAX_WIDTH) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(r_fw);
        end
        if (r_fh == '0) begin
            h_use = FhW'(1);
        end else if (int'(r_fh) > MaxHeight) begin
            h_use = FhW'(MaxHeight);
        end else begin
            h_use = r_fh;
        end
        total = CNTW'(w_use) * CNTW'(h_use);
        lag   = CNTW'(w_use) * CNTW'(REACH) + CNTW'(REACH);
    end

    assign room       = (int'(i_qcount) + int'(r_s1_vld)) < QueueDepth;
    assign issue      = r_pend && room;
    assign priming    = int'(r_pidx) < PRIME;
    assign last_issue = issue && !priming;
    assign o_ready    = !r_pend || last_issue;
    assign acc        = i_valid && o_ready;

    // fetch column and bank per window row, clamped to the frame
    always_comb begin
        int want, d, lo, hi, s;
        want = priming ? int'(r_pidx) - HALF : int'(r_p_col) + LEAD;
        if (want < 0) begin
            want = 0;
        end
        if (want > int'(w_use) - 1) begin
            want = int'(w_use) - 1;
        end
        rd_addr = AW'(want);
        lo = -int'(r_p_row);
        hi = int'(h_use) - 1 - int'(r_p_row);
        for (int i = 0; i < WINDOW; i++) begin
            d = i - HALF;
            if (d < lo) begin
                d = lo;
            end
            if (d > hi) begin
                d = hi;
            end
            s = int'(r_p_bank) + d;
            if (s < 0) begin
                s = s + RING;
            end else if (s >= RING) begin
                s = s - RING;
            end
            sel[i] = BW'(s);
        end
    end

    // raster bookkeeping per accepted transaction
    always_comb begin
        n_in_col   = r_in_col;
        n_in_bank  = r_in_bank;
        n_in_cnt   = r_in_cnt;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_bank = r_out_bank;
        n_out_cnt  = r_out_cnt;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_p_col    = r_p_col;
        n_p_row    = r_p_row;
        n_p_bank   = r_p_bank;
        n_p_fe     = r_p_fe;
        t_icol     = r_in_col;
        t_ibank    = r_in_bank;
        t_icnt     = r_in_cnt;
        t_ocol     = r_out_col;
        t_orow     = r_out_row;
        t_obank    = r_out_bank;
        t_ocnt     = r_out_cnt;
        emit       = 1'b0;
        we         = 1'b0;

        if (issue) begin
            if (priming) begin
                n_pidx = r_pidx + 1'b1;
            end else begin
                n_pend = 1'b0;
            end
        end

        if (i_cfg_we) begin
            n_in_col   = '0;
            n_in_bank  = '0;
            n_in_cnt   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_bank = '0;
            n_out_cnt  = '0;
        end else if (acc) begin
            if (i_drain) begin
                emit = (r_in_cnt == total) && (r_out_cnt < total);
            end else begin
                // pixel after a complete frame opens the next one
                if (r_in_cnt >= total) begin
                    t_icol  = '0;
                    t_ibank = '0;
                    t_icnt  = '0;
                    t_ocol  = '0;
                    t_orow  = '0;
                    t_obank = '0;
                    t_ocnt  = '0;
                end
                we = 1'b1;
                n_in_cnt = t_icnt + 1'b1;
                if (WW'(t_icol) == w_use - 1'b1) begin
                    n_in_col  = '0;
                    n_in_bank = (t_ibank == BW'(RING-1)) ? '0 : t_ibank + 1'b1;
                end else begin
                    n_in_col  = t_icol + 1'b1;
                    n_in_bank = t_ibank;
                end
                emit = (t_icnt + 1'b1) > lag;
                n_out_col  = t_ocol;
                n_out_row  = t_orow;
                n_out_bank = t_obank;
                n_out_cnt  = t_ocnt;
            end
            if (emit) begin
                n_pend   = 1'b1;
                n_pidx   = (t_ocol == '0) ? '0 : PW'(PRIME);
                n_p_col  = t_ocol;
                n_p_row  = t_orow;
                n_p_bank = t_obank;
                n_p_fe   = (t_ocnt + 1'b1) == total;
                n_out_cnt = t_ocnt + 1'b1;
                if (WW'(t_ocol) == w_use - 1'b1) begin
                    n_out_col  = '0;
                    n_out_row  = t_orow + 1'b1;
                    n_out_bank = (t_obank == BW'(RING-1)) ? '0 : t_obank + 1'b1;
                end else begin
                    n_out_col  = t_ocol + 1'b1;
                    n_out_row  = t_orow;
                    n_out_bank = t_obank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= FwW'(ResetWidth);
            r_fh       <= FhW'(ResetHeight);
            r_in_col   <= '0;
            r_in_bank  <= '0;
            r_in_cnt   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= '0;
            r_out_cnt  <= '0;
            r_pend     <= 1'b0;
            r_pidx     <= '0;
            r_s1_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_fw <= i_cfg_data[FwW-1:0];
                    CFG_HEIGHT: r_fh <= i_cfg_data;
                    default:    r_fh <= r_fh;
                endcase
            end
            r_in_col   <= n_in_col;
            r_in_bank  <= n_in_bank;
            r_in_cnt   <= n_in_cnt;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_bank <= n_out_bank;
            r_out_cnt  <= n_out_cnt;
            r_pend     <= n_pend;
            r_pidx     <= n_pidx;
            r_s1_vld   <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_col  <= n_p_col;
        r_p_row  <= n_p_row;
        r_p_bank <= n_p_bank;
        r_p_fe   <= n_p_fe;
        r_s1_ctl <= '{emit: !priming, frame_end: r_p_fe};
        r_s1_sel <= sel;
    end

    // one line store bank per ring row, all read at the same column
    for (genvar b = 0; b < RING; b++) begin : g_bank
        wmf_ram #(
            .WIDTH (PIXW),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we && (t_ibank == BW'(b))),
            .i_waddr (t_icol),
            .i_wdata (i_pix[PIXW-1:0]),
            .i_raddr (rd_addr),
            .o_rdata (rdata[b])
        );
    end

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            o_col[i*PIXW +: PIXW] = rdata[r_s1_sel[i]];
        end
    end

    assign o_push = r_s1_vld;
    assign o_ctl  = r_s1_ctl;

endmodule

FILE: rtl/wmf_back.sv
// Back end: window shift, rank-based median select, output register.
module wmf_back import wmf_pkg::*; #(
    parameter int WINDOW   = WindowDef,
    parameter int CHANNELS = ChannelsDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_qvalid,
    output logic                                 o_pop,
    input  t_op_ctl                              i_ctl,
    input  logic [WINDOW*((CHANNELS < OutChannels) ? CHANNELS : OutChannels)*SampleW-1:0] i_col,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [OutChannels*SampleW-1:0]       o_data,
    output logic                                 o_last
);

    localparam int CH   = (CHANNELS < OutChannels) ? CHANNELS : OutChannels;
    localparam int PIXW = CH * SampleW;
    localparam int NN   = WINDOW * WINDOW;
    localparam int MID  = NN / 2;
    localparam int RKW  = $clog2(NN);

    logic [PIXW-1:0] r_win [NN];
    logic [PIXW-1:0] n_win [NN];

    logic            r_b_vld, r_b_fe;
    logic [PIXW-1:0] r_b_win [NN];
    logic            r_c_vld, r_c_fe;
    logic [PIXW-1:0] r_c_win [NN];
    logic [NN-1:0]   r_c_sel [CH];
    logic [NN-1:0]   sel [CH];
    logic            r_o_vld, r_o_fe;
    logic [OutChannels*SampleW-1:0] r_o_data, med;

    logic o_adv, c_ready, b_ready;

    assign o_adv   = !r_o_vld || i_ready;
    assign c_ready = !r_c_vld || o_adv;
    assign b_ready = !r_b_vld || c_ready;
    assign o_pop   = i_qvalid && (!i_ctl.emit || b_ready);

    // shift columns left, new column enters on the right
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
                n_win[i*WINDOW+j] = r_win[i*WINDOW+j+1];
            end
            n_win[i*WINDOW+WINDOW-1] = i_col[i*PIXW +: PIXW];
        end
    end

    // rank of each element, ties broken by position
    always_comb begin
        logic [RKW-1:0]     rk;
        logic [SampleW-1:0] vk, vj;
        for (int c = 0; c < CH; c++) begin
            for (int k = 0; k < NN; k++) begin
                rk = '0;
                vk = r_b_win[k][c*SampleW +: SampleW];
                for (int j = 0; j < NN; j++) begin
                    vj = r_b_win[j][c*SampleW +: SampleW];
                    if (j != k && (vj < vk || (vj == vk && j < k))) begin
                        rk = rk + 1'b1;
                    end
                end
                sel[c][k] = (rk == RKW'(MID));
            end
        end
    end

    always_comb begin
        logic [SampleW-1:0] acc;
        med = '0;
        for (int c = 0; c < CH; c++) begin
            acc = '0;
            for (int k = 0; k < NN; k++) begin
                acc = acc | (r_c_win[k][c*SampleW +: SampleW] & {SampleW{r_c_sel[c][k]}});
            end
            med[c*SampleW +: SampleW] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_pop && i_ctl.emit) begin
                r_b_vld <= 1'b1;
            end else if (c_ready) begin
                r_b_vld <= 1'b0;
            end
            if (c_ready) begin
                r_c_vld <= r_b_vld;
            end
            if (o_adv) begin
                r_o_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win <= n_win;
        end
        if (o_pop && i_ctl.emit) begin
            r_b_win <= n_win;
            r_b_fe  <= i_ctl.frame_end;
        end
        if (c_ready) begin
            r_c_win <= r_b_win;
            r_c_sel <= sel;
            r_c_fe  <= r_b_fe;
        end
        if (o_adv) begin
            r_o_data <= med;
            r_o_fe   <= r_c_fe;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;
    assign o_last  = r_o_fe;

endmodule

FILE: rtl/windowed_median_image_filter_unit.sv
// Throughput: one pixel per cycle while the column queue has room and the output is not held;
//   the first pixel of each output row also fetches the WINDOW-1 columns that prime
//   the window from the line store.
// Bound by the single read port of each line store bank.
// Reset: synchronous active low; counters, handshakes cleared, size 640x480.
module windowed_median_image_filter_unit import wmf_pkg::*; #(
    parameter int WINDOW    = WindowDef,
    parameter int MAX_WIDTH = MaxWidthDef,
    parameter int CHANNELS  = ChannelsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [OutChannels*SampleW-1:0] s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                           s_axis_tuser,  // drain
    // filtered stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OutChannels*SampleW-1:0] m_axis_tdata,  // red_out, green_out, blue_out
    output logic                           m_axis_tlast,  // frame_end
    // register writes: 0 frame_width, 1 frame_height
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [FhW-1:0]                 i_cfg_data
);

    localparam int CH   = (CHANNELS < OutChannels) ? CHANNELS : OutChannels;
    localparam int COLW = WINDOW * CH * SampleW;
    localparam int QW   = COLW + $bits(t_op_ctl);

    logic                              push, pop, q_nempty;
    t_op_ctl                           push_ctl, pop_ctl;
    logic [COLW-1:0]                   push_col, pop_col;
    logic [QW-1:0]                     q_out;
    logic [$clog2(QueueDepth+1)-1:0]   q_count;

    // writes are always taken; they restart the frame
    assign o_cfg_ready = 1'b1;

    // front end: counts raster positions, writes line store, fetches columns
    wmf_front #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pix      (s_axis_tdata),
        .i_drain    (s_axis_tuser),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data (i_cfg_data),
        .i_qcount   (q_count),
        .o_push     (push),
        .o_ctl      (push_ctl),
        .o_col      (push_col)
    );

    // decoupling queue of fetched columns
    wmf_fifo #(
        .WIDTH (QW),
        .DEPTH (QueueDepth)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({push_ctl, push_col}),
        .i_pop    (pop),
        .o_data   (q_out),
        .o_nempty (q_nempty),
        .o_count  (q_count)
    );

    assign pop_ctl = t_op_ctl'(q_out[QW-1:COLW]);
    assign pop_col = q_out[COLW-1:0];

    // back end: window registers, median select, output register
    wmf_back #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (q_nempty),
        .o_pop    (pop),
        .i_ctl    (pop_ctl),
        .i_col    (pop_col),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

FILE: dv/median_checker.sv
// Scoreboard for the windowed median filter: predicts each output pixel and compares it.
`timescale 1ns / 1ps
module median_checker import wmf_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [OutChannels*SampleW-1:0] i_pix_data,
    input  logic                           i_pix_drain,
    input  logic                           i_med_valid,
    input  logic                           i_med_ready,
    input  logic [OutChannels*SampleW-1:0] i_med_data,
    input  logic                           i_med_last,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  t_cfg_idx                       i_cfg_index,
    input  logic [FhW-1:0]                 i_cfg_data,
    output int                             o_pending,
    output int                             o_errors,
    output int                             o_checked,
    output int                             o_frames
);
    localparam int Ring = 2 * WindowDef;
    localparam int Reach = (WindowDef - 1) / 2;

    typedef struct {
        logic [SampleW-1:0] red;
        logic [SampleW-1:0] green;
        logic [SampleW-1:0] blue;
        logic               last;
    } t_med_pixel;

    t_med_pixel expected_pixels[$];
    logic [OutChannels*SampleW-1:0] rows[Ring][MaxWidthDef];
    logic [FwW-1:0] width_reg;
    logic [FhW-1:0] height_reg;
    int in_col, in_row, out_col, out_row, in_cnt, out_cnt;

    function automatic int used_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MaxWidthDef) w = MaxWidthDef;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MaxHeight) h = MaxHeight;
        return h;
    endfunction

    function automatic int clamp(int v, int top);
        if (v < 0) return 0;
        if (v > top) return top;
        return v;
    endfunction

    function automatic logic [SampleW-1:0] channel_median(int ch, int w, int h);
        logic [SampleW-1:0] win[WindowDef*WindowDef];
        logic [SampleW-1:0] t;
        int k, y, x, j;
        k = 0;
        for (int i = 0; i < WindowDef; i++) begin
            y = clamp(out_row - WindowDef / 2 + i, h - 1);
            for (int m = 0; m < WindowDef; m++) begin
                x = clamp(out_col - WindowDef / 2 + m, w - 1);
                win[k] = rows[y % Ring][x][ch*SampleW +: SampleW];
                k++;
            end
        end
        // insertion sort, ascending
        for (int i = 1; i < WindowDef * WindowDef; i++) begin
            t = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > t) begin
                win[j+1] = win[j];
                j--;
            end
            win[j+1] = t;
        end
        return win[WindowDef*WindowDef/2];
    endfunction

    function automatic void predict_pixel(int w, int h);
        t_med_pixel p;
        p.red   = channel_median(0, w, h);
        p.green = channel_median(1, w, h);
        p.blue  = channel_median(2, w, h);
        out_cnt++;
        p.last = (out_cnt == w * h);
        if (p.last) o_frames++;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        expected_pixels.push_back(p);
    endfunction

    function automatic void restart();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_cnt = 0; out_cnt = 0;
    endfunction

    function automatic void take_item(logic [OutChannels*SampleW-1:0] d, logic drain);
        int w, h, total;
        w = used_width();
        h = used_height();
        total = w * h;
        if (drain) begin
            if (in_cnt == total && out_cnt < total) predict_pixel(w, h);
            return;
        end
        if (in_cnt >= total) restart();
        rows[in_row % Ring][in_col] = d;
        in_cnt++;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (in_cnt > Reach * w + Reach) predict_pixel(w, h);
    endfunction

    function automatic void compare(logic [OutChannels*SampleW-1:0] d, logic last);
        t_med_pixel p;
        if (expected_pixels.size() == 0) begin
            $error("unexpected output pixel %h last %0b", d, last);
            o_errors++;
            return;
        end
        p = expected_pixels.pop_front();
        o_checked++;
        if (d[7:0] !== p.red) begin
            $error("red_out expected %0d actual %0d", p.red, d[7:0]);
            o_errors++;
        end
        if (d[15:8] !== p.green) begin
            $error("green_out expected %0d actual %0d", p.green, d[15:8]);
            o_errors++;
        end
        if (d[23:16] !== p.blue) begin
            $error("blue_out expected %0d actual %0d", p.blue, d[23:16]);
            o_errors++;
        end
        if (last !== p.last) begin
            $error("frame_end expected %0b actual %0b", p.last, last);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors = 0;
        o_checked = 0;
        o_frames = 0;
        o_pending = 0;
        width_reg = FwW'(ResetWidth);
        height_reg = FhW'(ResetHeight);
        restart();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_med_valid && i_med_ready) compare(i_med_data, i_med_last);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) width_reg = i_cfg_data[FwW-1:0];
                else height_reg = i_cfg_data;
                restart();
            end
            if (i_pix_valid && i_pix_ready) take_item(i_pix_data, i_pix_drain);
            o_pending = expected_pixels.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the median filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench import wmf_pkg::*;;
    localparam int IdleLimit = 20000;   // cycles with no transaction before giving up
    localparam int RandomPixels = 750;

    logic i_clk, i_rst_n;
    logic s_valid, s_ready, s_drain;
    logic [OutChannels*SampleW-1:0] s_data;
    logic m_valid, m_ready, m_last;
    logic [OutChannels*SampleW-1:0] m_data;
    logic cfg_valid, cfg_ready;
    t_cfg_idx cfg_index;
    logic [FhW-1:0] cfg_data;
    int pending, errors, checked, frames;
    int idle_cycles, pixels_sent, drains_sent;
    logic steady;        // when set, neither side idles
    int hold_tag;        // bumped by stimulus to ask the receiver for a long hold-off
    int hold_seen, hold_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    windowed_median_image_filter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_drain),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tlast (m_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    median_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_valid(s_valid),
        .i_pix_ready(s_ready),
        .i_pix_data (s_data),
        .i_pix_drain(s_drain),
        .i_med_valid(m_valid),
        .i_med_ready(m_ready),
        .i_med_data (m_data),
        .i_med_last (m_last),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors),
        .o_checked  (checked),
        .o_frames   (frames)
    );

    // Receiver: random backpressure, plus a long hold-off on request.
    initial begin
        hold_seen = 0;
        hold_left = 0;
    end
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    // Watchdog: any stretch without a transaction on any channel is bounded.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("windowed_median_image_filter_unit test failed");
            $finish;
        end
    end

    // One pixel or drain transaction; gaps keep tvalid low in between.
    task automatic send_item(input logic [OutChannels*SampleW-1:0] d, input logic drain);
        int gap;
        gap = steady ? 0 : (($urandom_range(99) < 35) ? $urandom_range(2, 1) : 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        s_drain <= drain;
        do @(posedge i_clk); while (!s_ready);
        if (drain) drains_sent++;
        else pixels_sent++;
    endtask

    // Let the block run dry before touching registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [FhW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [FhW-1:0] w, input logic [FhW-1:0] h);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic [SampleW-1:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return SampleW'($urandom);
    endfunction

    function automatic logic [OutChannels*SampleW-1:0] rand_pixel();
        return {rand_sample(), rand_sample(), rand_sample()};
    endfunction

    task automatic send_drains(input int n);
        repeat (n) send_item(rand_pixel(), 1'b1);
    endtask

    initial begin
        int w, h, n;
        logic [OutChannels*SampleW-1:0] corner[9];
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_drain = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        steady = 1'b0;
        hold_tag = 0;
        idle_cycles = 0;
        pixels_sent = 0;
        drains_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame of extreme and checkerboard samples; an early drain is ignored
        corner = '{24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55, 24'hFF00FF,
                   24'h00FF00, 24'h0F0F0F, 24'hF0F0F0, 24'h123456};
        set_size(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 5) send_item(24'hFFFFFF, 1'b1);
            send_item(corner[i], 1'b0);
        end
        send_drains(6);    // the last ones fall past the frame and are ignored

        // width written as 4096 masks to zero and height zero: both act as one
        set_size(13'h1000, 13'd0);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'h000000, 1'b0);   // new frame, the undrained pixel is dropped
        send_drains(3);

        // saturating sizes: height above 4096 on a one-column frame, left unfinished
        set_size(13'd1, 13'h1FFF);
        for (int i = 0; i < 30; i++) send_item(rand_pixel(), 1'b0);
        // width above the maximum saturates; partial row, drains before its end are ignored
        set_size(13'd4095, 13'd1);
        for (int i = 0; i < 20; i++) send_item(rand_pixel(), 1'b0);
        send_drains(2);

        // random frames: mostly complete and fully drained, some truncated
        n = 0;
        while (pixels_sent + drains_sent < RandomPixels) begin
            if (n == 0 || $urandom_range(99) < 50) begin
                w = ($urandom_range(99) < 90) ? $urandom_range(16, 1) : $urandom_range(40, 17);
                h = $urandom_range(6, 1);
                set_size(FhW'(w), FhW'(h));
            end
            steady = (n >= 2 && n < 6);
            if (n == 4) begin
                set_size(13'd12, 13'd6);
                w = 12;
                h = 6;
            end
            for (int i = 0; i < w * h; i++) begin
                if (n == 4 && i == 20) hold_tag <= hold_tag + 1;  // block backs up
                if ($urandom_range(99) < 4) send_item(rand_pixel(), 1'b1);
                send_item(rand_pixel(), 1'b0);
            end
            if ($urandom_range(99) < 85) send_drains(w + 3);
            else send_drains($urandom_range(w, 0));
            if (n % 5 == 4) wait_idle();       // sender pauses until all results are in
            n++;
        end
        steady = 1'b0;

        wait_idle();
        $display("Checked %0d filtered pixels over %0d completed frames", checked, frames);
        $display("Fed %0d pixels and %0d drain transactions", pixels_sent, drains_sent);
        if (errors == 0) begin
            $display("windowed_median_image_filter_unit test passed");
        end else begin
            $display("windowed_median_image_filter_unit test failed");
        end
        $finish;
    end

endmodule
